// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted
`define SAGP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define SAGP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sagp_pkg.sv -----
`timescale 1ns / 1ps

package sagp_pkg;

    localparam int POS_W      = 16;
    localparam int DIFF_W     = 17;
    localparam int SQ_W       = 34;
    localparam int DOT_W      = 35;
    localparam int DIST_W     = 17;
    localparam int MAXD_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int ATT_QW     = 16;
    localparam int DOP_QW     = 13;
    localparam int DOP_NUM_W  = 39;
    localparam int DOP_DEN_W  = 26;
    localparam int SPEED_W    = 9;
    localparam int FACTOR_W   = 14;

    localparam logic [GAIN_W-1:0]   UNITY_Q15    = 16'd32768;
    localparam logic [FACTOR_W-1:0] UNITY_Q12    = 14'd4096;
    localparam logic [FACTOR_W-1:0] DOP_MIN      = 14'd2048;
    localparam logic [FACTOR_W-1:0] DOP_MAX      = 14'd8192;
    localparam logic [SPEED_W-1:0]  SOUND_SPEED  = 9'd343;
    // distance below 0.1: 100 * S < 65536
    localparam logic [SQ_W-1:0]     NEAR_LIMIT   = 34'd656;
    localparam logic [MAXD_W-1:0]   MAXD_RESET   = 15'd12800;
    localparam logic [GAIN_W-1:0]   MUSIC_RESET  = 16'd22938;

    typedef enum logic [2:0] {
        REG_LISTENER_POS  = 3'd0,
        REG_LISTENER_VEL  = 3'd1,
        REG_MAX_DIST      = 3'd2,
        REG_MASTER_GAIN   = 3'd3,
        REG_EFFECTS_GAIN  = 3'd4,
        REG_MUSIC_GAIN    = 3'd5,
        REG_SPEECH_GAIN   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLASS_EFFECTS = 2'd0,
        CLASS_MUSIC   = 2'd1,
        CLASS_SPEECH  = 2'd2,
        CLASS_UNITY   = 2'd3
    } audio_class_t;

    typedef struct packed {
        logic              spatial;
        logic [GAIN_W-1:0] volume;
        logic [15:0]       base_pitch;
        logic [GAIN_W-1:0] cls_gain;
    } voice_t;

    typedef struct packed {
        logic far;
        logic dop_en;
        logic neg;
        logic sat;
    } dop_ctl_t;

endpackage

// ----- sv/sagp_front.sv -----
`timescale 1ns / 1ps

module sagp_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ce,
    input  logic                                  in_valid,
    input  logic signed [sagp_pkg::POS_W-1:0]     source_x,
    input  logic signed [sagp_pkg::POS_W-1:0]     source_y,
    input  logic signed [sagp_pkg::POS_W-1:0]     source_z,
    input  sagp_pkg::voice_t                      voice_in,
    input  logic [47:0]                           listener_position,
    input  logic [47:0]                           listener_vel,
    output logic                                  out_valid,
    output logic [sagp_pkg::SQ_W-1:0]             sq_sum,
    output logic signed [sagp_pkg::DOT_W-1:0]     dot,
    output logic                                  near,
    output sagp_pkg::voice_t                      voice_out
);

    logic [2:0]                             valid_reg;
    logic signed [sagp_pkg::POS_W-1:0]      src [3];
    logic signed [sagp_pkg::DIFF_W-1:0]     d_reg [3];
    logic signed [sagp_pkg::DIFF_W-1:0]     d_next [3];
    logic [32:0]                            sq_reg [3];
    logic [32:0]                            sq_next [3];
    logic signed [32:0]                     pr_reg [3];
    logic signed [32:0]                     pr_next [3];
    logic [sagp_pkg::SQ_W-1:0]              sum_reg, sum_next;
    logic signed [sagp_pkg::DOT_W-1:0]      dot_reg, dot_next;
    logic                                   near_reg, near_next;
    sagp_pkg::voice_t                       voice1_reg, voice2_reg, voice3_reg;

    assign src[0] = source_x;
    assign src[1] = source_y;
    assign src[2] = source_z;

    always_comb
    begin
        logic signed [33:0] sq_full;
        for (int k = 0; k < 3; k++)
        begin
            d_next[k]  = {src[k][15], src[k]}
                       - {listener_position[16*k+15], listener_position[16*k +: 16]};
            sq_full    = d_reg[k] * d_reg[k];
            sq_next[k] = sq_full[32:0];
            pr_next[k] = $signed(listener_vel[16*k +: 16]) * d_reg[k];
        end
        sum_next  = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
        dot_next  = {{2{pr_reg[0][32]}}, pr_reg[0]}
                  + {{2{pr_reg[1][32]}}, pr_reg[1]}
                  + {{2{pr_reg[2][32]}}, pr_reg[2]};
        near_next = sum_next < sagp_pkg::NEAR_LIMIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ce)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k]  <= d_next[k];
                sq_reg[k] <= sq_next[k];
                pr_reg[k] <= pr_next[k];
            end
            voice1_reg <= voice_in;
            voice2_reg <= voice1_reg;
            sum_reg    <= sum_next;
            dot_reg    <= dot_next;
            near_reg   <= near_next;
            voice3_reg <= voice2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign sq_sum    = sum_reg;
    assign dot       = dot_reg;
    assign near      = near_reg;
    assign voice_out = voice3_reg;

endmodule

// ----- sv/sagp_sqrt.sv -----
`timescale 1ns / 1ps

module sagp_sqrt (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ce,
    input  logic                                  in_valid,
    input  logic [sagp_pkg::SQ_W-1:0]             sq_sum,
    input  logic signed [sagp_pkg::DOT_W-1:0]     dot,
    input  logic                                  near,
    input  sagp_pkg::voice_t                      voice_in,
    output logic                                  out_valid,
    output logic [sagp_pkg::DIST_W-1:0]           distance,
    output logic signed [sagp_pkg::DOT_W-1:0]     dot_out,
    output logic                                  near_out,
    output sagp_pkg::voice_t                      voice_out
);

    localparam int STEPS = sagp_pkg::DIST_W;
    localparam int ACC_W = sagp_pkg::SQ_W + 1;
    localparam logic [ACC_W-1:0] ONE = 1;

    logic [STEPS-1:0]                   valid_reg;
    logic [STEPS-1:0]                   near_reg;
    logic [ACC_W-1:0]                   rem_reg [STEPS];
    logic [ACC_W-1:0]                   rem_next [STEPS];
    logic [ACC_W-1:0]                   res_reg [STEPS];
    logic [ACC_W-1:0]                   res_next [STEPS];
    logic signed [sagp_pkg::DOT_W-1:0]  dot_reg [STEPS];
    sagp_pkg::voice_t                   voice_reg [STEPS];

    // one result bit per stage, bit-pair method from the top
    always_comb
    begin
        logic [ACC_W-1:0] rem_in;
        logic [ACC_W-1:0] res_in;
        logic [ACC_W-1:0] bitv;
        logic [ACC_W-1:0] trial;
        for (int s = 0; s < STEPS; s++)
        begin
            if (s == 0)
            begin
                rem_in = {1'b0, sq_sum};
                res_in = '0;
            end
            else
            begin
                rem_in = rem_reg[s-1];
                res_in = res_reg[s-1];
            end
            bitv  = ONE << (2 * (STEPS - 1 - s));
            trial = res_in + bitv;
            if (rem_in >= trial)
            begin
                rem_next[s] = rem_in - trial;
                res_next[s] = (res_in >> 1) + bitv;
            end
            else
            begin
                rem_next[s] = rem_in;
                res_next[s] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ce)
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            near_reg <= {near_reg[STEPS-2:0], near};
            for (int s = 0; s < STEPS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                res_reg[s] <= res_next[s];
                if (s == 0)
                begin
                    dot_reg[s]   <= dot;
                    voice_reg[s] <= voice_in;
                end
                else
                begin
                    dot_reg[s]   <= dot_reg[s-1];
                    voice_reg[s] <= voice_reg[s-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign distance  = res_reg[STEPS-1][sagp_pkg::DIST_W-1:0];
    assign dot_out   = dot_reg[STEPS-1];
    assign near_out  = near_reg[STEPS-1];
    assign voice_out = voice_reg[STEPS-1];

endmodule

// ----- sv/sagp_div.sv -----
`timescale 1ns / 1ps

module sagp_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ce,
    input  logic                                  in_valid,
    input  logic [sagp_pkg::DIST_W-1:0]           distance,
    input  logic signed [sagp_pkg::DOT_W-1:0]     dot,
    input  logic                                  near,
    input  sagp_pkg::voice_t                      voice_in,
    input  logic [sagp_pkg::MAXD_W-1:0]           falloff_len,
    output logic                                  out_valid,
    output logic [sagp_pkg::ATT_QW-1:0]           atten_q,
    output logic [sagp_pkg::DOP_QW-1:0]           dop_q,
    output sagp_pkg::dop_ctl_t                    ctl_out,
    output sagp_pkg::voice_t                      voice_out
);

    localparam int STEPS  = sagp_pkg::ATT_QW;
    localparam int AREM_W = sagp_pkg::MAXD_W + sagp_pkg::ATT_QW;
    localparam int DREM_W = sagp_pkg::DOP_NUM_W;
    localparam int DEN_W  = sagp_pkg::DOP_DEN_W;
    localparam int QD_W   = sagp_pkg::DOP_QW;

    logic                               valid_a_reg, valid_b_reg;
    sagp_pkg::dop_ctl_t                 ctl_a_reg, ctl_a_next, ctl_b_reg, ctl_b_next;
    logic [sagp_pkg::MAXD_W-1:0]        diff_a_reg, diff_a_next, diff_b_reg;
    logic [DEN_W-1:0]                   den_a_reg, den_a_next, den_b_reg;
    logic [DREM_W-1:0]                  num_a_reg, num_a_next, num_b_reg;
    logic [sagp_pkg::DOT_W-1:0]         mag;
    sagp_pkg::voice_t                   voice_a_reg, voice_b_reg;

    logic [STEPS-1:0]                   valid_reg;
    logic [AREM_W-1:0]                  arem_reg [STEPS];
    logic [AREM_W-1:0]                  arem_next [STEPS];
    logic [DREM_W-1:0]                  drem_reg [STEPS];
    logic [DREM_W-1:0]                  drem_next [STEPS];
    logic [DEN_W-1:0]                   dden_reg [STEPS];
    logic [DEN_W-1:0]                   dden_next [STEPS];
    logic [STEPS-1:0]                   qa_reg [STEPS];
    logic [STEPS-1:0]                   qa_next [STEPS];
    logic [QD_W-1:0]                    qd_reg [STEPS];
    logic [QD_W-1:0]                    qd_next [STEPS];
    sagp_pkg::dop_ctl_t                 ctl_reg [STEPS];
    sagp_pkg::voice_t                   voice_reg [STEPS];

    // range check, falloff numerator, Doppler numerator and denominator
    always_comb
    begin
        mag = dot[sagp_pkg::DOT_W-1] ? $unsigned(-dot) : $unsigned(dot);
        ctl_a_next.far    = voice_in.spatial
                          && (distance >= {{(sagp_pkg::DIST_W-sagp_pkg::MAXD_W){1'b0}},
                                           falloff_len});
        ctl_a_next.dop_en = voice_in.spatial && !near;
        ctl_a_next.neg    = dot[sagp_pkg::DOT_W-1];
        ctl_a_next.sat    = 1'b0;
        diff_a_next       = falloff_len - distance[sagp_pkg::MAXD_W-1:0];
        den_a_next        = {{(DEN_W-sagp_pkg::DIST_W){1'b0}}, distance}
                          * {{(DEN_W-sagp_pkg::SPEED_W){1'b0}}, sagp_pkg::SOUND_SPEED};
        num_a_next        = {mag, 4'b0000};
    end

    // quotient would not fit the Doppler bits: clamp later
    always_comb
    begin
        ctl_b_next     = ctl_a_reg;
        ctl_b_next.sat = num_a_reg[DREM_W-1:QD_W] >= den_a_reg;
    end

    // restoring division, one quotient bit per stage (Doppler: i<QD_W)
    always_comb
    begin
        logic [AREM_W-1:0] ar;
        logic [AREM_W-1:0] ad;
        logic [DREM_W-1:0] dr;
        logic [DREM_W-1:0] dd_sh;
        logic [DEN_W-1:0]  dd;
        logic [STEPS-1:0]  qa;
        logic [QD_W-1:0]   qd;
        int                i;
        for (int s = 0; s < STEPS; s++)
        begin
            i = STEPS - 1 - s;
            if (s == 0)
            begin
                ar = {1'b0, diff_b_reg, {(STEPS-1){1'b0}}};
                dr = num_b_reg;
                dd = den_b_reg;
                qa = '0;
                qd = '0;
            end
            else
            begin
                ar = arem_reg[s-1];
                dr = drem_reg[s-1];
                dd = dden_reg[s-1];
                qa = qa_reg[s-1];
                qd = qd_reg[s-1];
            end
            ad = {{(AREM_W-sagp_pkg::MAXD_W){1'b0}}, falloff_len} << i;
            if (ar >= ad)
            begin
                arem_next[s] = ar - ad;
                qa_next[s]   = {qa[STEPS-2:0], 1'b1};
            end
            else
            begin
                arem_next[s] = ar;
                qa_next[s]   = {qa[STEPS-2:0], 1'b0};
            end
            dd_sh = {{(DREM_W-DEN_W){1'b0}}, dd} << i;
            if (i >= QD_W)
            begin
                drem_next[s] = dr;
                qd_next[s]   = qd;
            end
            else if (dr >= dd_sh)
            begin
                drem_next[s] = dr - dd_sh;
                qd_next[s]   = {qd[QD_W-2:0], 1'b1};
            end
            else
            begin
                drem_next[s] = dr;
                qd_next[s]   = {qd[QD_W-2:0], 1'b0};
            end
            dden_next[s] = dd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_reg   <= '0;
        end
        else if (ce)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_reg   <= {valid_reg[STEPS-2:0], valid_b_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ctl_a_reg   <= ctl_a_next;
            diff_a_reg  <= diff_a_next;
            den_a_reg   <= den_a_next;
            num_a_reg   <= num_a_next;
            voice_a_reg <= voice_in;
            ctl_b_reg   <= ctl_b_next;
            diff_b_reg  <= diff_a_reg;
            den_b_reg   <= den_a_reg;
            num_b_reg   <= num_a_reg;
            voice_b_reg <= voice_a_reg;
            for (int s = 0; s < STEPS; s++)
            begin
                arem_reg[s] <= arem_next[s];
                drem_reg[s] <= drem_next[s];
                dden_reg[s] <= dden_next[s];
                qa_reg[s]   <= qa_next[s];
                qd_reg[s]   <= qd_next[s];
                if (s == 0)
                begin
                    ctl_reg[s]   <= ctl_b_reg;
                    voice_reg[s] <= voice_b_reg;
                end
                else
                begin
                    ctl_reg[s]   <= ctl_reg[s-1];
                    voice_reg[s] <= voice_reg[s-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign atten_q   = qa_reg[STEPS-1];
    assign dop_q     = qd_reg[STEPS-1];
    assign ctl_out   = ctl_reg[STEPS-1];
    assign voice_out = voice_reg[STEPS-1];

endmodule

// ----- sv/sagp_back.sv -----
`timescale 1ns / 1ps

module sagp_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ce,
    input  logic                                  in_valid,
    input  logic [sagp_pkg::ATT_QW-1:0]           atten_q,
    input  logic [sagp_pkg::DOP_QW-1:0]           dop_q,
    input  sagp_pkg::dop_ctl_t                    ctl_in,
    input  sagp_pkg::voice_t                      voice_in,
    input  logic [sagp_pkg::GAIN_W-1:0]           master_gain,
    output logic                                  out_valid,
    output logic [sagp_pkg::GAIN_W-1:0]           final_gain,
    output logic [15:0]                           final_pitch,
    output logic                                  out_of_range
);

    localparam int FW = sagp_pkg::FACTOR_W;

    logic [3:0]                         valid_reg;
    logic [3:0]                         far_reg;
    logic [sagp_pkg::GAIN_W-1:0]        att1_reg, att1_next;
    logic [FW-1:0]                      fac1_reg, fac1_next;
    sagp_pkg::voice_t                   voice1_reg, voice2_reg;
    logic [sagp_pkg::DOP_QW-1:0]        mag;
    logic [31:0]                        p1;
    logic [29:0]                        pp;
    logic [16:0]                        pt;
    logic [15:0]                        g1_reg, pitch2_reg, pitch2_next;
    logic [31:0]                        p2;
    logic [16:0]                        g2_reg;
    logic [15:0]                        pitch3_reg, pitch4_reg;
    logic [32:0]                        p3;
    logic [17:0]                        g3;
    logic [sagp_pkg::GAIN_W-1:0]        gain4_reg, gain4_next;

    always_comb
    begin
        mag = ctl_in.sat ? '1 : dop_q;
        priority if (!ctl_in.dop_en)
            fac1_next = sagp_pkg::UNITY_Q12;
        else if (ctl_in.neg)
            fac1_next = ({1'b0, mag} >= (sagp_pkg::UNITY_Q12 - sagp_pkg::DOP_MIN))
                      ? sagp_pkg::DOP_MIN : sagp_pkg::UNITY_Q12 - {1'b0, mag};
        else
            fac1_next = ({1'b0, mag} >= (sagp_pkg::DOP_MAX - sagp_pkg::UNITY_Q12))
                      ? sagp_pkg::DOP_MAX : sagp_pkg::UNITY_Q12 + {1'b0, mag};

        priority if (!voice_in.spatial)
            att1_next = sagp_pkg::UNITY_Q15;
        else if (ctl_in.far)
            att1_next = '0;
        else
            att1_next = atten_q;

        p1          = {16'b0, voice1_reg.volume} * {16'b0, att1_reg};
        pp          = {14'b0, voice1_reg.base_pitch} * {16'b0, fac1_reg};
        pt          = pp[28:12];
        pitch2_next = pt[16] ? 16'hFFFF : pt[15:0];

        p2          = {16'b0, g1_reg} * {16'b0, voice2_reg.cls_gain};

        p3          = {16'b0, g2_reg} * {17'b0, master_gain};
        g3          = p3[32:15];
        gain4_next  = (g3 > {2'b0, sagp_pkg::UNITY_Q15}) ? sagp_pkg::UNITY_Q15 : g3[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ce)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            far_reg    <= {far_reg[2:0], ctl_in.far};
            att1_reg   <= att1_next;
            fac1_reg   <= fac1_next;
            voice1_reg <= voice_in;
            g1_reg     <= p1[30:15];
            pitch2_reg <= pitch2_next;
            voice2_reg <= voice1_reg;
            g2_reg     <= p2[31:15];
            pitch3_reg <= pitch2_reg;
            gain4_reg  <= gain4_next;
            pitch4_reg <= pitch3_reg;
        end
    end

    assign out_valid    = valid_reg[3];
    assign final_gain   = gain4_reg;
    assign final_pitch  = pitch4_reg;
    assign out_of_range = far_reg[3];

endmodule

// ----- sv/spatial_audio_gain_pitch.sv -----
`timescale 1ns / 1ps

// Gain and pitch of one sound voice. A voice request on the s_ side gives one result request
// on the m_ side; the block takes one voice every clock while the skid stage is empty, and
// results pass through the 17-stage square root, the 18-stage falloff and Doppler
// divider and the multiply chain. In spatial mode the gain falls off linearly to zero at
// the maximum distance and the pitch gets a Doppler factor clamped to 0.5..2.0; class and
// master gains then apply. An output register with a skid stage keeps s_tready independent
// of m_tready. Configuration writes take effect at once and belong between voices.
module spatial_audio_gain_pitch (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // source_x, source_y, source_z, volume, base_pitch
    input  logic [2:0]  s_tuser,   // audio_class, spatial
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // final_gain, final_pitch, out_of_range, zero fill
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [47:0]                        lpos_reg, lvel_reg;
    logic [sagp_pkg::MAXD_W-1:0]        maxd_reg;
    logic [sagp_pkg::GAIN_W-1:0]        master_reg, fx_reg, music_reg, speech_reg;

    logic                               ce;
    sagp_pkg::voice_t                   voice_in;

    logic                               f_valid, q_valid, d_valid, b_valid;
    logic [sagp_pkg::SQ_W-1:0]          f_sq;
    logic signed [sagp_pkg::DOT_W-1:0]  f_dot, q_dot;
    logic                               f_near, q_near;
    sagp_pkg::voice_t                   f_voice, q_voice, d_voice;
    logic [sagp_pkg::DIST_W-1:0]        q_dist;
    logic [sagp_pkg::ATT_QW-1:0]        d_atten;
    logic [sagp_pkg::DOP_QW-1:0]        d_dop;
    sagp_pkg::dop_ctl_t                 d_ctl;
    logic [15:0]                        b_gain, b_pitch;
    logic                               b_far;
    logic [39:0]                        res_data;

    logic                               out_valid_reg, out_valid_next;
    logic [39:0]                        out_data_reg, out_data_next;
    logic                               skid_valid_reg, skid_valid_next;
    logic [39:0]                        skid_data_reg, skid_data_next;
    logic                               incoming;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpos_reg   <= '0;
            lvel_reg   <= '0;
            maxd_reg   <= sagp_pkg::MAXD_RESET;
            master_reg <= sagp_pkg::UNITY_Q15;
            fx_reg     <= sagp_pkg::UNITY_Q15;
            music_reg  <= sagp_pkg::MUSIC_RESET;
            speech_reg <= sagp_pkg::UNITY_Q15;
        end
        else if (cfg_we)
        begin
            unique case (sagp_pkg::cfg_reg_t'(cfg_index))
                sagp_pkg::REG_LISTENER_POS: lpos_reg   <= cfg_data;
                sagp_pkg::REG_LISTENER_VEL: lvel_reg   <= cfg_data;
                sagp_pkg::REG_MAX_DIST:     maxd_reg   <= cfg_data[sagp_pkg::MAXD_W-1:0];
                sagp_pkg::REG_MASTER_GAIN:  master_reg <= cfg_data[sagp_pkg::GAIN_W-1:0];
                sagp_pkg::REG_EFFECTS_GAIN: fx_reg     <= cfg_data[sagp_pkg::GAIN_W-1:0];
                sagp_pkg::REG_MUSIC_GAIN:   music_reg  <= cfg_data[sagp_pkg::GAIN_W-1:0];
                sagp_pkg::REG_SPEECH_GAIN:  speech_reg <= cfg_data[sagp_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        voice_in.spatial     = s_tuser[2];
        voice_in.volume      = s_tdata[63:48];
        voice_in.base_pitch  = s_tdata[79:64];
        unique case (sagp_pkg::audio_class_t'(s_tuser[1:0]))
            sagp_pkg::CLASS_EFFECTS: voice_in.cls_gain = fx_reg;
            sagp_pkg::CLASS_MUSIC:   voice_in.cls_gain = music_reg;
            sagp_pkg::CLASS_SPEECH:  voice_in.cls_gain = speech_reg;
            sagp_pkg::CLASS_UNITY:   voice_in.cls_gain = sagp_pkg::UNITY_Q15;
        endcase
    end

    // whole pipeline moves unless the skid stage is holding a result
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    sagp_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .ce                (ce),
        .in_valid          (s_tvalid),
        .source_x          (s_tdata[15:0]),
        .source_y          (s_tdata[31:16]),
        .source_z          (s_tdata[47:32]),
        .voice_in          (voice_in),
        .listener_position (lpos_reg),
        .listener_vel      (lvel_reg),
        .out_valid         (f_valid),
        .sq_sum            (f_sq),
        .dot               (f_dot),
        .near              (f_near),
        .voice_out         (f_voice)
    );

    sagp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (f_valid),
        .sq_sum    (f_sq),
        .dot       (f_dot),
        .near      (f_near),
        .voice_in  (f_voice),
        .out_valid (q_valid),
        .distance  (q_dist),
        .dot_out   (q_dot),
        .near_out  (q_near),
        .voice_out (q_voice)
    );

    sagp_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .ce           (ce),
        .in_valid     (q_valid),
        .distance     (q_dist),
        .dot          (q_dot),
        .near         (q_near),
        .voice_in     (q_voice),
        .falloff_len  (maxd_reg),
        .out_valid    (d_valid),
        .atten_q      (d_atten),
        .dop_q        (d_dop),
        .ctl_out      (d_ctl),
        .voice_out    (d_voice)
    );

    sagp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ce           (ce),
        .in_valid     (d_valid),
        .atten_q      (d_atten),
        .dop_q        (d_dop),
        .ctl_in       (d_ctl),
        .voice_in     (d_voice),
        .master_gain  (master_reg),
        .out_valid    (b_valid),
        .final_gain   (b_gain),
        .final_pitch  (b_pitch),
        .out_of_range (b_far)
    );

    assign res_data = {7'b0, b_far, b_pitch, b_gain};
    assign incoming = b_valid && ce;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = incoming;
                out_data_next  = res_data;
            end
        end
        else if (incoming)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sv/sagp_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sagp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `SAGP_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result request dropped")
    `SAGP_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")
    `SAGP_ASSERT(a_far_mute, m_tvalid && m_tdata[32] |-> m_tdata[15:0] == 16'd0, "far voice not muted")
    `SAGP_ASSERT(a_gain_cap, m_tvalid |-> m_tdata[15:0] <= 16'd32768, "gain above unity")
    // output register is cleared asynchronously while reset is low
    `SAGP_ASSERT_RST(a_rst_quiet, !rst_n |=> !m_tvalid, "result during reset")

endmodule

bind spatial_audio_gain_pitch sagp_checker u_sagp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
